// File: hw/rtl/qs_pkg.sv
package qs_pkg;

    // Defaults for the top level parameters.
    localparam int FRAC_BITS_DEF     = 14;
    localparam int CORDIC_STAGES_DEF = 16;

    // Internal word widths.
    localparam int CW     = 34;   // CORDIC datapath, Q30 with headroom
    localparam int SQ_W   = 63;   // square root remainder
    localparam int ROOT_W = 31;   // square root result, Q30
    localparam int DIV_QW = 34;   // weight quotient bits
    localparam int DIV_RW = 34;   // divider remainder and divisor
    localparam int DIV_MW = 33;   // divider numerator magnitude
    localparam int K_W    = 35;   // signed weight

    // 0.9999 in Q30.
    localparam logic [63:0] NEAR_LIMIT = 64'd1073634449;

    typedef logic signed [CW-1:0] t_cw;

    typedef struct packed {
        logic signed [15:0] a_w;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic [14:0]        frac;
    } t_in;

    typedef struct packed {
        logic signed [15:0] r_w;
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
    } t_out;

    // Operands that travel beside the long chains.
    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][16:0] b;
        logic [30:0]      t30;
        logic             near;
    } t_side;

    // Arctangent of 2^-idx in Q30 radians.
    function automatic t_cw atan_q30(input int idx);
        t_cw v;
        case (idx)
            0:       v = t_cw'(64'd843314857);
            1:       v = t_cw'(64'd497837829);
            2:       v = t_cw'(64'd263043837);
            3:       v = t_cw'(64'd133525159);
            4:       v = t_cw'(64'd67021687);
            5:       v = t_cw'(64'd33543516);
            6:       v = t_cw'(64'd16775851);
            7:       v = t_cw'(64'd8388437);
            8:       v = t_cw'(64'd4194283);
            9:       v = t_cw'(64'd2097149);
            default: v = (idx <= 30) ? t_cw'(64'd1 << (30 - idx)) : '0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/qs_if.sv
interface qs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/qs_sqrt_cell.sv
module qs_sqrt_cell import qs_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SQ_W-1:0]   i_rem,
    input  logic [ROOT_W-1:0] i_root,
    output logic [SQ_W-1:0]   o_rem,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SQ_W-1:0]   trial;

    // Trial subtrahend (2*root + 2^bit) * 2^bit for one root bit.
    assign trial = (SQ_W'(i_root) << (BIT + 1)) + (SQ_W'(1) << (2 * BIT));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_rem >= trial) begin
                r_rem  <= i_rem - trial;
                r_root <= i_root | (ROOT_W'(1) << BIT);
            end else begin
                r_rem  <= i_rem;
                r_root <= i_root;
            end
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// File: hw/rtl/qs_cordic_cell.sv
module qs_cordic_cell import qs_pkg::*; #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_cw  i_x,
    input  t_cw  i_y,
    input  t_cw  i_z,
    output t_cw  o_x,
    output t_cw  o_y,
    output t_cw  o_z
);

    localparam t_cw ATAN = atan_q30(STAGE);

    t_cw  r_x;
    t_cw  r_y;
    t_cw  r_z;
    t_cw  dx;
    t_cw  dy;
    logic up;

    // Vectoring drives y to zero, rotation drives z to zero.
    assign dx = i_y >>> STAGE;
    assign dy = i_x >>> STAGE;
    assign up = VECTOR ? !(i_y > 0) : (i_z >= 0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (up) begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_z <= i_z + ATAN;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// File: hw/rtl/qs_div_cell.sv
module qs_div_cell import qs_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_RW-1:0] i_rem,
    input  logic [DIV_QW-1:0] i_quo,
    input  logic [DIV_RW-1:0] i_den,
    input  logic [DIV_MW-1:0] i_num,
    output logic [DIV_RW-1:0] o_rem,
    output logic [DIV_QW-1:0] o_quo,
    output logic [DIV_RW-1:0] o_den,
    output logic [DIV_MW-1:0] o_num
);

    logic [DIV_RW-1:0] r_rem;
    logic [DIV_QW-1:0] r_quo;
    logic [DIV_RW-1:0] r_den;
    logic [DIV_MW-1:0] r_num;
    logic              dbit;
    logic [DIV_RW-1:0] trial;

    // The dividend is the numerator shifted up by thirty places.
    if (BIT >= 30) begin : g_num_bit
        assign dbit = i_num[BIT-30];
    end else begin : g_zero_bit
        assign dbit = 1'b0;
    end

    assign trial = {i_rem[DIV_RW-2:0], dbit};

    // One restoring step: one quotient bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= i_den;
            r_num <= i_num;
            if (trial >= i_den) begin
                r_rem <= trial - i_den;
                r_quo <= i_quo | (DIV_QW'(1) << BIT);
            end else begin
                r_rem <= trial;
                r_quo <= i_quo;
            end
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_den = r_den;
    assign o_num = r_num;

endmodule

// File: hw/rtl/quaternion_slerp.sv
// Channel  Dir  Fields                               Handshake
// i_in     in   a_w a_x a_y a_z b_w b_x b_y b_z frac  valid/ready
// o_out    out  r_w r_x r_y r_z                      valid/ready
//
// One item is accepted every cycle while no skid item is held; the pipeline
// is made of stage registers and cell chains: 31 square root cells, two
// CORDIC chains and 34 divider cells in each of two lanes.
// Reset clears only the valid bits; there is no clearing pass.
// A full skid register freezes the whole pipeline and drops i_in.ready.
module quaternion_slerp import qs_pkg::*; #(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    qs_if.sink   i_in,
    qs_if.source o_out
);

    localparam int SH_R = (2 * FRAC_BITS > 30) ? 2 * FRAC_BITS - 30 : 0;
    localparam int SH_L = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
    localparam int T_SH = 30 - FRAC_BITS;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
    localparam logic signed [22:0] HI = (FRAC_BITS < 15) ?
        23'(64'd1 << FRAC_BITS) : 23'sd32767;
    localparam logic signed [22:0] LO = (FRAC_BITS < 15) ?
        -23'(64'd1 << FRAC_BITS) : -23'sd32768;
    localparam int N = CORDIC_STAGES;
    localparam t_cw X_ONE = t_cw'(64'd1 << 30);

    logic en;
    logic r_skid_v;
    logic r_out_v;
    t_out r_skid;
    t_out r_out;
    t_out res;

    assign en         = !r_skid_v;
    assign i_in.ready = en;

    // Stage 1: component products and fraction in Q30.
    logic [3:0][15:0]        in_a;
    logic [3:0][15:0]        in_b;
    logic [63:0]             tsat;
    logic                    r1_v;
    logic signed [31:0]      r1_prod [4];
    logic [3:0][15:0]        r1_a;
    logic [3:0][15:0]        r1_b;
    logic [30:0]             r1_t30;

    always_comb begin
        in_a = {i_in.data.a_z, i_in.data.a_y, i_in.data.a_x, i_in.data.a_w};
        in_b = {i_in.data.b_z, i_in.data.b_y, i_in.data.b_x, i_in.data.b_w};
        tsat = (64'(i_in.data.frac) > ONE) ? ONE : 64'(i_in.data.frac);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r1_prod[i] <= $signed(in_a[i]) * $signed(in_b[i]);
            end
            r1_a   <= in_a;
            r1_b   <= in_b;
            r1_t30 <= 31'(tsat << T_SH);
        end
    end

    // Stage 2: dot product, shorter arc, cosine in Q30.
    logic signed [33:0] dot;
    logic               dot_neg;
    logic [33:0]        mag;
    logic [63:0]        cwide;
    t_side              side2;
    logic               r2_v;
    t_side              r2_side;
    logic [30:0]        r2_c;

    always_comb begin
        dot = 34'(r1_prod[0]) + 34'(r1_prod[1]) + 34'(r1_prod[2]) + 34'(r1_prod[3]);
        dot_neg = dot < 0;
        mag = dot_neg ? $unsigned(-dot) : $unsigned(dot);
        cwide = ({30'd0, mag} >> SH_R) << SH_L;
        side2.a = r1_a;
        for (int i = 0; i < 4; i++) begin
            side2.b[i] = dot_neg ? $unsigned(-17'($signed(r1_b[i])))
                                 : $unsigned(17'($signed(r1_b[i])));
        end
        side2.t30  = r1_t30;
        side2.near = cwide > NEAR_LIMIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side <= side2;
            r2_c    <= cwide[30:0];
        end
    end

    // Stages 3 and 4: cosine squared, then one minus it in Q60.
    logic        r3_v;
    logic        r4_v;
    t_side       r3_side;
    t_side       r4_side;
    logic [30:0] r3_c;
    logic [30:0] r4_c;
    logic [61:0] r3_cc;
    logic [SQ_W-1:0] r4_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_cc   <= r2_c * r2_c;
            r3_c    <= r2_c;
            r3_side <= r2_side;
            r4_n    <= SQ_W'(64'd1 << 60) - SQ_W'(r3_cc);
            r4_c    <= r3_c;
            r4_side <= r3_side;
        end
    end

    // Square root chain: one root bit per cell.
    logic [SQ_W-1:0]   sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root [ROOT_W+1];
    logic              r_sq_v    [ROOT_W+1];
    t_side             r_sq_side [ROOT_W+1];
    logic [30:0]       r_sq_c    [ROOT_W+1];

    assign sq_rem[0]    = r4_n;
    assign sq_root[0]   = '0;
    assign r_sq_v[0]    = r4_v;
    assign r_sq_side[0] = r4_side;
    assign r_sq_c[0]    = r4_c;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
        qs_sqrt_cell #(.BIT(ROOT_W - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_side[k+1] <= r_sq_side[k];
                r_sq_c[k+1]    <= r_sq_c[k];
            end
        end
    end

    // Angle chain: vectoring CORDIC on (cosine, sine).
    t_cw   an_x [N+1];
    t_cw   an_y [N+1];
    t_cw   an_z [N+1];
    logic  r_an_v    [N+1];
    t_side r_an_side [N+1];

    assign an_x[0]      = $signed({3'b000, r_sq_c[ROOT_W]});
    assign an_y[0]      = $signed({3'b000, sq_root[ROOT_W]});
    assign an_z[0]      = '0;
    assign r_an_v[0]    = r_sq_v[ROOT_W];
    assign r_an_side[0] = r_sq_side[ROOT_W];

    for (genvar k = 0; k < N; k++) begin : g_an
        qs_cordic_cell #(.STAGE(k), .VECTOR(1'b1)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (an_x[k]),
            .i_y   (an_y[k]),
            .i_z   (an_z[k]),
            .o_x   (an_x[k+1]),
            .o_y   (an_y[k+1]),
            .o_z   (an_z[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_an_v[k+1] <= 1'b0;
            end else if (en) begin
                r_an_v[k+1] <= r_an_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_an_side[k+1] <= r_an_side[k];
            end
        end
    end

    // Stages 5 and 6: t*w, then the three sine arguments.
    logic [31:0] wu;
    logic [32:0] tw;
    logic        r5_v;
    logic        r6_v;
    t_side       r5_side;
    t_side       r6_side;
    logic [31:0] r5_w;
    logic [62:0] r5_prod;
    t_cw         r6_z [3];

    assign wu = (an_z[N] < 0) ? '0 : an_z[N][31:0];
    assign tw = r5_prod[62:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (en) begin
            r5_v <= r_an_v[N];
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_prod <= r_an_side[N].t30 * wu;
            r5_w    <= wu;
            r5_side <= r_an_side[N];
            r6_z[0] <= $signed({2'b00, r5_w}) - $signed({1'b0, tw});
            r6_z[1] <= $signed({1'b0, tw});
            r6_z[2] <= $signed({2'b00, r5_w});
            r6_side <= r5_side;
        end
    end

    // Sine chains: three rotation lanes, (1-t)w, tw and w.
    t_cw   sn_x [3][N+1];
    t_cw   sn_y [3][N+1];
    t_cw   sn_z [3][N+1];
    logic  r_sn_v    [N+1];
    t_side r_sn_side [N+1];

    assign r_sn_v[0]    = r6_v;
    assign r_sn_side[0] = r6_side;

    for (genvar j = 0; j < 3; j++) begin : g_lane
        assign sn_x[j][0] = X_ONE;
        assign sn_y[j][0] = '0;
        assign sn_z[j][0] = r6_z[j];

        for (genvar k = 0; k < N; k++) begin : g_sn
            qs_cordic_cell #(.STAGE(k), .VECTOR(1'b0)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_x   (sn_x[j][k]),
                .i_y   (sn_y[j][k]),
                .i_z   (sn_z[j][k]),
                .o_x   (sn_x[j][k+1]),
                .o_y   (sn_y[j][k+1]),
                .o_z   (sn_z[j][k+1])
            );
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_sn_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sn_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sn_v[k+1] <= r_sn_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sn_side[k+1] <= r_sn_side[k];
            end
        end
    end

    // Stage 7: numerator magnitudes and signs, divisor sin(w).
    logic              r7_v;
    t_side             r7_side;
    logic              r7_pos;
    logic [1:0]        r7_neg;
    logic [DIV_MW-1:0] r7_num [2];
    logic [DIV_RW-1:0] r7_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r_sn_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_side <= r_sn_side[N];
            r7_pos  <= sn_y[2][N] > 0;
            r7_den  <= DIV_RW'($unsigned(sn_y[2][N]));
            for (int j = 0; j < 2; j++) begin
                r7_neg[j] <= sn_y[j][N] < 0;
                r7_num[j] <= (sn_y[j][N] < 0) ? DIV_MW'($unsigned(-sn_y[j][N]))
                                              : DIV_MW'($unsigned(sn_y[j][N]));
            end
        end
    end

    // Divider chains: one quotient bit per cell, two lanes.
    logic [DIV_RW-1:0] dv_rem [2][DIV_QW+1];
    logic [DIV_QW-1:0] dv_quo [2][DIV_QW+1];
    logic [DIV_RW-1:0] dv_den [2][DIV_QW+1];
    logic [DIV_MW-1:0] dv_num [2][DIV_QW+1];
    logic              r_dv_v    [DIV_QW+1];
    t_side             r_dv_side [DIV_QW+1];
    logic              r_dv_pos  [DIV_QW+1];
    logic [1:0]        r_dv_neg  [DIV_QW+1];

    assign r_dv_v[0]    = r7_v;
    assign r_dv_side[0] = r7_side;
    assign r_dv_pos[0]  = r7_pos;
    assign r_dv_neg[0]  = r7_neg;

    for (genvar j = 0; j < 2; j++) begin : g_dlane
        assign dv_rem[j][0] = DIV_RW'(r7_num[j] >> (DIV_QW - 30));
        assign dv_quo[j][0] = '0;
        assign dv_den[j][0] = r7_den;
        assign dv_num[j][0] = r7_num[j];

        for (genvar k = 0; k < DIV_QW; k++) begin : g_dv
            qs_div_cell #(.BIT(DIV_QW - 1 - k)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (dv_rem[j][k]),
                .i_quo (dv_quo[j][k]),
                .i_den (dv_den[j][k]),
                .i_num (dv_num[j][k]),
                .o_rem (dv_rem[j][k+1]),
                .o_quo (dv_quo[j][k+1]),
                .o_den (dv_den[j][k+1]),
                .o_num (dv_num[j][k+1])
            );
        end
    end

    for (genvar k = 0; k < DIV_QW; k++) begin : g_dv_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_side[k+1] <= r_dv_side[k];
                r_dv_pos[k+1]  <= r_dv_pos[k];
                r_dv_neg[k+1]  <= r_dv_neg[k];
            end
        end
    end

    // Stage 8: choose sine or linear weights.
    t_side                 dv_side;
    logic                  linear;
    logic signed [K_W-1:0] k0_lin;
    logic signed [K_W-1:0] kq [2];
    logic                  r8_v;
    t_side                 r8_side;
    logic signed [K_W-1:0] r8_k [2];

    always_comb begin
        dv_side = r_dv_side[DIV_QW];
        linear  = dv_side.near || !r_dv_pos[DIV_QW];
        k0_lin  = $signed(K_W'(64'd1 << 30)) - $signed({4'b0000, dv_side.t30});
        for (int j = 0; j < 2; j++) begin
            kq[j] = r_dv_neg[DIV_QW][j] ? -$signed({1'b0, dv_quo[j][DIV_QW]})
                                        : $signed({1'b0, dv_quo[j][DIV_QW]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= r_dv_v[DIV_QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_side <= dv_side;
            r8_k[0] <= linear ? k0_lin : kq[0];
            r8_k[1] <= linear ? $signed({4'b0000, dv_side.t30}) : kq[1];
        end
    end

    // Stage 9: weighted components.
    logic               r9_v;
    logic signed [51:0] r9_pa [4];
    logic signed [51:0] r9_pb [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r9_pa[i] <= $signed(r8_side.a[i]) * r8_k[0];
                r9_pb[i] <= $signed(r8_side.b[i]) * r8_k[1];
            end
        end
    end

    // Sum, round to nearest and saturate.
    logic signed [52:0] acc [4];
    logic signed [22:0] rnd [4];
    logic [3:0][15:0]   rsat;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            acc[i] = 53'(r9_pa[i]) + 53'(r9_pb[i]) + $signed(53'(64'd1 << 29));
            rnd[i] = acc[i][52:30];
            if (rnd[i] > HI) begin
                rsat[i] = HI[15:0];
            end else if (rnd[i] < LO) begin
                rsat[i] = LO[15:0];
            end else begin
                rsat[i] = rnd[i][15:0];
            end
        end
        res.r_w = rsat[0];
        res.r_x = rsat[1];
        res.r_y = rsat[2];
        res.r_z = rsat[3];
    end

    // Output register with a skid item behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r9_v;
            end
        end else if (r9_v && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_out.ready) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (r9_v && !r_skid_v) begin
            r_skid <= res;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid item held with no output item");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !o_out.ready) |=> (r_skid_v && r_out_v))
        else $error("skid item lost while output stalled");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> ($signed(r_out.r_w) <= HI && $signed(r_out.r_w) >= LO &&
                     $signed(r_out.r_z) <= HI && $signed(r_out.r_z) >= LO))
        else $error("result component outside the saturation range");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r9_v))
        else $error("pipeline moved while skid item held");
`endif

endmodule
